// File: hw/rtl/wrapped_rect_splitter_core_defines.svh
// Assertion macros used by the splitter core RTL.
`ifndef WRAPPED_RECT_SPLITTER_CORE_DEFINES_SVH
`define WRAPPED_RECT_SPLITTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define WRS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("splitter assertion failed");

`define WRS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("splitter assertion failed");

`else

`define WRS_ASSERT_IMP(label, clk, rst, ante, cons)

`define WRS_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/wrs_pkg.sv
package wrs_pkg;

   localparam int COORD_BITS = 12;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COORD_BITS:0]   wide_type;

   // Remainder is built a few dividend bits per pipeline stage.
   localparam int DIV_DIGIT  = 4;
   localparam int DIV_STAGES = (COORD_BITS + DIV_DIGIT - 1) / DIV_DIGIT;
   localparam int DIV_W      = DIV_STAGES * DIV_DIGIT;

   typedef logic [DIV_DIGIT-1:0] digit_type;
   typedef logic [DIV_W-1:0]     dividend_type;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [1:0] csr_idx_type;

   localparam csr_idx_type CSR_DEV_WIDTH    = 2'd0;
   localparam csr_idx_type CSR_DEV_HEIGHT   = 2'd1;
   localparam csr_idx_type CSR_IMAGE_HEIGHT = 2'd2;

   localparam coord_type DEV_WIDTH_RST    = coord_type'(512);
   localparam coord_type DEV_HEIGHT_RST   = coord_type'(480);
   localparam coord_type IMAGE_HEIGHT_RST = coord_type'(960);

   typedef struct packed {
      coord_type rect_left;
      coord_type rect_top;
      coord_type rect_right;
      coord_type rect_bottom;
   } req_type;

   typedef struct packed {
      coord_type src_left;
      coord_type src_low_edge;
      coord_type src_right;
      coord_type src_high_edge;
      coord_type dst_left;
      coord_type dst_low_edge;
      coord_type dst_right;
      coord_type dst_high_edge;
      logic      too_big;
      logic      last_piece;
   } rsp_type;

   typedef struct packed {
      req_type   req;
      coord_type h;
      coord_type v;
      logic      empty;
      coord_type rem_x;
      coord_type rem_y;
   } stage_type;

   // Everything the piece sequencer needs for one rectangle.
   typedef struct packed {
      logic      big;
      logic      split_x;
      logic      split_y;
      coord_type l;
      coord_type bx;
      coord_type r;
      coord_type t;
      coord_type by;
      coord_type b;
      coord_type dl;
      coord_type x_a_end;
      coord_type x_b_end;
      coord_type dt;
      coord_type y_a_end;
      coord_type y_b_end;
   } item_type;

   // A few restoring division steps; only the remainder is kept.
   function automatic coord_type div_digit(coord_type rem, digit_type bits, coord_type d);
      coord_type r_loc;
      wide_type  acc;
      r_loc = rem;
      for (int i = DIV_DIGIT - 1; i >= 0; i--) begin
         acc = {r_loc, bits[i]};
         if (acc >= {1'b0, d}) begin
            acc = acc - {1'b0, d};
         end
         r_loc = acc[COORD_BITS-1:0];
      end
      return r_loc;
   endfunction

endpackage

// File: hw/rtl/wrs_emitter.sv
module wrs_emitter (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  wrs_pkg::item_type   item,
   input  wrs_pkg::coord_type  dev_height,
   input  wrs_pkg::coord_type  image_height,
   output logic                load_ready,
   output logic                rsp_valid,
   output wrs_pkg::rsp_type    rsp_data
);

   wrs_pkg::item_type  cur_ff;
   logic               cur_valid_ff;
   logic [1:0]         idx_ff;
   logic               rsp_valid_ff;
   wrs_pkg::rsp_type   rsp_data_ff;
   wrs_pkg::rsp_type   rsp_data_in;

   logic               px;
   logic               py;
   logic               last;
   logic               load;
   wrs_pkg::coord_type st;
   wrs_pkg::coord_type sb;
   wrs_pkg::coord_type dtop;
   wrs_pkg::coord_type dbot;

   // Pieces go out upper row first, left before right.
   always_comb begin
      unique case ({cur_ff.split_y, cur_ff.split_x})
         2'b00: begin
            px   = 1'b0;
            py   = 1'b0;
            last = 1'b1;
         end
         2'b01: begin
            px   = idx_ff[0];
            py   = 1'b0;
            last = idx_ff[0];
         end
         2'b10: begin
            px   = 1'b0;
            py   = idx_ff[0];
            last = idx_ff[0];
         end
         default: begin
            px   = idx_ff[0];
            py   = idx_ff[1];
            last = &idx_ff;
         end
      endcase
      if (cur_ff.big) begin
         last = 1'b1;
      end
   end

   assign load_ready = !cur_valid_ff || last;
   assign load       = item_valid && load_ready;

   always_comb begin
      st   = py ? cur_ff.by : cur_ff.t;
      sb   = (!py && cur_ff.split_y) ? cur_ff.by : cur_ff.b;
      dtop = py ? '0 : cur_ff.dt;
      dbot = py ? cur_ff.y_b_end : cur_ff.y_a_end;
      rsp_data_in.src_left      = px ? cur_ff.bx : cur_ff.l;
      rsp_data_in.src_right     = (!px && cur_ff.split_x) ? cur_ff.bx : cur_ff.r;
      rsp_data_in.src_low_edge  = image_height - sb;
      rsp_data_in.src_high_edge = image_height - st;
      rsp_data_in.dst_left      = px ? '0 : cur_ff.dl;
      rsp_data_in.dst_right     = px ? cur_ff.x_b_end : cur_ff.x_a_end;
      rsp_data_in.dst_low_edge  = dev_height - dbot;
      rsp_data_in.dst_high_edge = dev_height - dtop;
      rsp_data_in.too_big       = 1'b0;
      rsp_data_in.last_piece    = last;
      if (cur_ff.big) begin
         rsp_data_in            = '0;
         rsp_data_in.too_big    = 1'b1;
         rsp_data_in.last_piece = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cur_valid_ff;
         if (load) begin
            cur_valid_ff <= 1'b1;
            idx_ff       <= '0;
         end else if (cur_valid_ff) begin
            cur_valid_ff <= !last;
            idx_ff       <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= item;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/wrapped_rect_splitter_core.sv
// The first result of a request passes the entry register, the remainder pipeline (three stages
// of 4-bit restoring steps), the piece register and the output register.
// Throughput: one result per cycle; a request holds the piece sequencer until all of its pieces
// (1, 2 or 4) are out, so busy rises behind a split request. Empty requests never enter it.
// Reset (synchronous, active high) drops all requests in flight and restores the registers
// to 512 / 480 / 960. Results cannot be held off by the receiver.
`include "wrapped_rect_splitter_core_defines.svh"

module wrapped_rect_splitter_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  wrs_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output wrs_pkg::rsp_type                    rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wrs_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [wrs_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [wrs_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   wrs_pkg::coord_type   dev_width_ff;
   wrs_pkg::coord_type   dev_height_ff;
   wrs_pkg::coord_type   image_height_ff;
   wrs_pkg::csr_idx_type csr_idx;
   logic                 csr_wr;

   logic                 vld_ff [0:wrs_pkg::DIV_STAGES];
   wrs_pkg::stage_type   st_ff  [0:wrs_pkg::DIV_STAGES];
   wrs_pkg::stage_type   st_in  [0:wrs_pkg::DIV_STAGES];
   wrs_pkg::stage_type   last_stage;

   logic                 stall;
   logic                 item_valid;
   logic                 load_ready;
   wrs_pkg::item_type    item;

   wrs_pkg::wide_type    ex;
   wrs_pkg::wide_type    ey;
   wrs_pkg::wide_type    ex_wrap;
   wrs_pkg::wide_type    ey_wrap;
   wrs_pkg::wide_type    bx_w;
   wrs_pkg::wide_type    by_w;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_width_ff    <= wrs_pkg::DEV_WIDTH_RST;
         dev_height_ff   <= wrs_pkg::DEV_HEIGHT_RST;
         image_height_ff <= wrs_pkg::IMAGE_HEIGHT_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            wrs_pkg::CSR_DEV_WIDTH:    dev_width_ff    <= csr_pwdata[wrs_pkg::COORD_BITS-1:0];
            wrs_pkg::CSR_DEV_HEIGHT:   dev_height_ff   <= csr_pwdata[wrs_pkg::COORD_BITS-1:0];
            wrs_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_pwdata[wrs_pkg::COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         wrs_pkg::CSR_DEV_WIDTH:    csr_prdata = wrs_pkg::CSR_DATA_BITS'(dev_width_ff);
         wrs_pkg::CSR_DEV_HEIGHT:   csr_prdata = wrs_pkg::CSR_DATA_BITS'(dev_height_ff);
         wrs_pkg::CSR_IMAGE_HEIGHT: csr_prdata = wrs_pkg::CSR_DATA_BITS'(image_height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // Entry stage: extents and the empty check.
   always_comb begin
      st_in[0].req   = req_data;
      st_in[0].h     = req_data.rect_right - req_data.rect_left;
      st_in[0].v     = req_data.rect_bottom - req_data.rect_top;
      st_in[0].empty = (req_data.rect_right <= req_data.rect_left) ||
                       (req_data.rect_bottom <= req_data.rect_top);
      st_in[0].rem_x = '0;
      st_in[0].rem_y = '0;
   end

   // Remainder stages: each consumes the next dividend digit of both axes.
   for (genvar k = 0; k < wrs_pkg::DIV_STAGES; k++) begin : g_div
      wrs_pkg::dividend_type pad_x;
      wrs_pkg::dividend_type pad_y;
      assign pad_x = wrs_pkg::DIV_W'(st_ff[k].req.rect_left);
      assign pad_y = wrs_pkg::DIV_W'(st_ff[k].req.rect_top);
      always_comb begin
         st_in[k+1]       = st_ff[k];
         st_in[k+1].rem_x = wrs_pkg::div_digit(st_ff[k].rem_x,
            pad_x[wrs_pkg::DIV_W-1-k*wrs_pkg::DIV_DIGIT -: wrs_pkg::DIV_DIGIT],
            dev_width_ff);
         st_in[k+1].rem_y = wrs_pkg::div_digit(st_ff[k].rem_y,
            pad_y[wrs_pkg::DIV_W-1-k*wrs_pkg::DIV_DIGIT -: wrs_pkg::DIV_DIGIT],
            dev_height_ff);
      end
   end

   // Stages advance together; they all hold while the last stage has an item the sequencer cannot take.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= wrs_pkg::DIV_STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (!stall) begin
         vld_ff[0] <= start;
         for (int k = 0; k < wrs_pkg::DIV_STAGES; k++) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         for (int k = 0; k <= wrs_pkg::DIV_STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign last_stage = st_ff[wrs_pkg::DIV_STAGES];

   // Split decision. The tile boundary is l - (l mod d) + d, so no multiply is needed.
   always_comb begin
      ex      = {1'b0, last_stage.rem_x} + {1'b0, last_stage.h};
      ey      = {1'b0, last_stage.rem_y} + {1'b0, last_stage.v};
      ex_wrap = ex - {1'b0, dev_width_ff};
      ey_wrap = ey - {1'b0, dev_height_ff};
      bx_w    = {1'b0, last_stage.req.rect_left} - {1'b0, last_stage.rem_x}
                + {1'b0, dev_width_ff};
      by_w    = {1'b0, last_stage.req.rect_top} - {1'b0, last_stage.rem_y}
                + {1'b0, dev_height_ff};

      item.big     = (dev_width_ff == '0) || (dev_height_ff == '0) ||
                     (last_stage.h > dev_width_ff) || (last_stage.v > dev_height_ff);
      item.split_x = ex > {1'b0, dev_width_ff};
      item.split_y = ey > {1'b0, dev_height_ff};
      item.l       = last_stage.req.rect_left;
      item.r       = last_stage.req.rect_right;
      item.t       = last_stage.req.rect_top;
      item.b       = last_stage.req.rect_bottom;
      item.bx      = bx_w[wrs_pkg::COORD_BITS-1:0];
      item.by      = by_w[wrs_pkg::COORD_BITS-1:0];
      item.dl      = last_stage.rem_x;
      item.dt      = last_stage.rem_y;
      item.x_a_end = item.split_x ? dev_width_ff : ex[wrs_pkg::COORD_BITS-1:0];
      item.y_a_end = item.split_y ? dev_height_ff : ey[wrs_pkg::COORD_BITS-1:0];
      item.x_b_end = ex_wrap[wrs_pkg::COORD_BITS-1:0];
      item.y_b_end = ey_wrap[wrs_pkg::COORD_BITS-1:0];
   end

   assign item_valid = vld_ff[wrs_pkg::DIV_STAGES] && !last_stage.empty;
   assign stall      = item_valid && !load_ready;
   assign busy       = stall;

   wrs_emitter u_emitter (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .dev_height   (dev_height_ff),
      .image_height (image_height_ff),
      .load_ready   (load_ready),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

   // An oversized rectangle is reported as a single piece.
   `WRS_ASSERT_IMP(a_big_is_last, clock, reset, rsp_valid && rsp_data.too_big, rsp_data.last_piece)
   // Pieces of one rectangle leave on consecutive cycles.
   `WRS_ASSERT_NXT(a_pieces_back_to_back, clock, reset, rsp_valid && !rsp_data.last_piece, rsp_valid)
   // A stalled pipeline keeps its oldest request intact.
   `WRS_ASSERT_NXT(a_hold_on_busy, clock, reset, busy, $stable(last_stage) && vld_ff[wrs_pkg::DIV_STAGES])

endmodule

// File: sim/wrapped_rect_splitter_checker.sv
module wrapped_rect_splitter_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  wrs_pkg::req_type                  req_data,
   input  logic                              rsp_valid,
   input  wrs_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wrs_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [wrs_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                              csr_pready,
   output int                                fail_count,
   output int                                pending,
   output int                                pieces_seen
);
   import wrs_pkg::*;

   coord_type cfg_dev_w;
   coord_type cfg_dev_h;
   coord_type cfg_img_h;

   rsp_type expected_pieces[$];
   int      mismatches;
   int      seen;

   // Builds one source/destination pair, flipping both to lower-left origin.
   function automatic rsp_type make_piece(int unsigned sl, int unsigned st, int unsigned sr,
                                          int unsigned sb, int unsigned dl, int unsigned dt,
                                          int unsigned dr, int unsigned db, bit is_last);
      rsp_type p;
      p.src_left      = coord_type'(sl);
      p.src_low_edge  = coord_type'(int'(cfg_img_h) - int'(sb));
      p.src_right     = coord_type'(sr);
      p.src_high_edge = coord_type'(int'(cfg_img_h) - int'(st));
      p.dst_left      = coord_type'(dl);
      p.dst_low_edge  = coord_type'(int'(cfg_dev_h) - int'(db));
      p.dst_right     = coord_type'(dr);
      p.dst_high_edge = coord_type'(int'(cfg_dev_h) - int'(dt));
      p.too_big       = 1'b0;
      p.last_piece    = is_last;
      return p;
   endfunction

   // Queues the pieces that one rectangle is expected to produce, in output order.
   function automatic void split_rect(req_type rq);
      int unsigned l, t, r, b, h, v, dw, dh, dl, dt, bx, by;
      rsp_type     p;
      bit          fit_x, fit_y;
      l = rq.rect_left;
      t = rq.rect_top;
      r = rq.rect_right;
      b = rq.rect_bottom;
      if (r <= l || b <= t) begin
         return;
      end
      h  = r - l;
      v  = b - t;
      dw = cfg_dev_w;
      dh = cfg_dev_h;
      if (dw == 0 || dh == 0 || h > dw || v > dh) begin
         p            = '0;
         p.too_big    = 1'b1;
         p.last_piece = 1'b1;
         expected_pieces.push_back(p);
         return;
      end
      dl    = l % dw;
      dt    = t % dh;
      bx    = (l / dw + 1) * dw;
      by    = (t / dh + 1) * dh;
      fit_x = (dl + h <= dw);
      fit_y = (dt + v <= dh);
      if (fit_x && fit_y) begin
         expected_pieces.push_back(make_piece(l, t, r, b, dl, dt, dl + h, dt + v, 1'b1));
      end else if (fit_x) begin
         expected_pieces.push_back(make_piece(l, t, r, by, dl, dt, dl + h, dh, 1'b0));
         expected_pieces.push_back(make_piece(l, by, r, b, dl, 0, dl + h, dt + v - dh, 1'b1));
      end else if (fit_y) begin
         expected_pieces.push_back(make_piece(l, t, bx, b, dl, dt, dw, dt + v, 1'b0));
         expected_pieces.push_back(make_piece(bx, t, r, b, 0, dt, dl + h - dw, dt + v, 1'b1));
      end else begin
         expected_pieces.push_back(make_piece(l, t, bx, by, dl, dt, dw, dh, 1'b0));
         expected_pieces.push_back(make_piece(bx, t, r, by, 0, dt, dl + h - dw, dh, 1'b0));
         expected_pieces.push_back(make_piece(l, by, bx, b, dl, 0, dw, dt + v - dh, 1'b0));
         expected_pieces.push_back(make_piece(bx, by, r, b, 0, 0, dl + h - dw, dt + v - dh,
                                              1'b1));
      end
   endfunction

   function automatic string piece_text(rsp_type p);
      return $sformatf("src %0d %0d %0d %0d dst %0d %0d %0d %0d too_big %0b last %0b",
                       p.src_left, p.src_low_edge, p.src_right, p.src_high_edge,
                       p.dst_left, p.dst_low_edge, p.dst_right, p.dst_high_edge,
                       p.too_big, p.last_piece);
   endfunction

   always @(posedge clock) begin
      rsp_type     want;
      csr_idx_type idx;
      if (reset) begin
         expected_pieces.delete();
         mismatches = 0;
         seen       = 0;
         cfg_dev_w = DEV_WIDTH_RST;
         cfg_dev_h = DEV_HEIGHT_RST;
         cfg_img_h = IMAGE_HEIGHT_RST;
      end else begin
         if (rsp_valid) begin
            seen++;
            if (expected_pieces.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: unexpected piece: %s", $realtime, piece_text(rsp_data));
               end
            end else begin
               want = expected_pieces.pop_front();
               if (rsp_data.src_left      !== want.src_left      ||
                   rsp_data.src_low_edge  !== want.src_low_edge  ||
                   rsp_data.src_right     !== want.src_right     ||
                   rsp_data.src_high_edge !== want.src_high_edge ||
                   rsp_data.dst_left      !== want.dst_left      ||
                   rsp_data.dst_low_edge  !== want.dst_low_edge  ||
                   rsp_data.dst_right     !== want.dst_right     ||
                   rsp_data.dst_high_edge !== want.dst_high_edge ||
                   rsp_data.too_big       !== want.too_big       ||
                   rsp_data.last_piece    !== want.last_piece) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: piece mismatch", $realtime);
                     $display("   expected %s", piece_text(want));
                     $display("   actual   %s", piece_text(rsp_data));
                  end
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            idx = csr_idx_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
            case (idx)
               CSR_DEV_WIDTH: begin
                  cfg_dev_w = coord_type'(csr_pwdata);
               end
               CSR_DEV_HEIGHT: begin
                  cfg_dev_h = coord_type'(csr_pwdata);
               end
               CSR_IMAGE_HEIGHT: begin
                  cfg_img_h = coord_type'(csr_pwdata);
               end
               default: begin
               end
            endcase
         end
         if (start && !busy) begin
            split_rect(req_data);
         end
      end
      fail_count  <= mismatches;
      pending     <= expected_pieces.size();
      pieces_seen <= seen;
   end

endmodule

// File: sim/tb_wrapped_rect_splitter_core.sv
module tb_wrapped_rect_splitter_core;
   import wrs_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   req_type                    req_data;
   logic                       rsp_valid;
   rsp_type                    rsp_data;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]   csr_paddr;
   logic [CSR_DATA_BITS-1:0]   csr_pwdata;
   logic [CSR_DATA_BITS-1:0]   csr_prdata;
   logic                       csr_pready;

   int fail_count;
   int pending;
   int pieces_seen;
   int cycle_count = 0;
   int rects_sent;
   int settings_used;
   int calm_left;

   // Geometry currently programmed, used to shape the random rectangles.
   int geo_w;
   int geo_h;

   wrapped_rect_splitter_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   wrapped_rect_splitter_checker i_piece_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending),
      .pieces_seen (pieces_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic req_type rect(int l, int t, int r, int b);
      req_type rq;
      rq.rect_left   = coord_type'(l);
      rq.rect_top    = coord_type'(t);
      rq.rect_right  = coord_type'(r);
      rq.rect_bottom = coord_type'(b);
      return rq;
   endfunction

   // Start position for a span: either anywhere, or just short of a tile end so it wraps.
   function automatic int place(int span, int period);
      int pos;
      if ($urandom_range(0, 1) == 0) begin
         pos = $urandom_range(0, 4095 - span);
      end else begin
         pos = period * $urandom_range(0, 4095 / period) + period - $urandom_range(1, span);
      end
      if (pos + span > 4095) begin
         pos = 4095 - span;
      end
      if (pos < 0) begin
         pos = 0;
      end
      return pos;
   endfunction

   function automatic req_type random_rect();
      int      kind, dw, dh, w, hgt, l, t;
      req_type rq;
      kind = $urandom_range(0, 19);
      dw   = (geo_w == 0) ? 1 : geo_w;
      dh   = (geo_h == 0) ? 1 : geo_h;
      if (kind == 0) begin
         rq = rect($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095));
         return rq;
      end
      if (kind == 1) begin
         // Empty or inverted in one axis or the other.
         l = $urandom_range(0, 4095);
         t = $urandom_range(0, 4095);
         if ($urandom_range(0, 1) == 0) begin
            rq = rect(l, t, $urandom_range(0, l), $urandom_range(0, 4095));
         end else begin
            rq = rect(l, t, $urandom_range(0, 4095), $urandom_range(0, t));
         end
         return rq;
      end
      w   = ($urandom_range(0, 1) == 0) ? $urandom_range(1, dw)
                                        : $urandom_range(1, (dw < 16) ? dw : 16);
      hgt = ($urandom_range(0, 1) == 0) ? $urandom_range(1, dh)
                                        : $urandom_range(1, (dh < 16) ? dh : 16);
      if (kind == 2) begin
         w = dw + $urandom_range(1, 64);
      end else if (kind == 3) begin
         hgt = dh + $urandom_range(1, 64);
      end
      l  = place(w, dw);
      t  = place(hgt, dh);
      rq = rect(l, t, l + w, t + hgt);
      return rq;
   endfunction

   task automatic send_rect(req_type rq);
      int gap;
      if (calm_left == 0 && $urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(5, 20);
      end
      if (calm_left > 0) begin
         gap = 0;
         calm_left--;
      end else begin
         gap = $urandom_range(0, 5);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      rects_sent++;
   endtask

   // Lets every outstanding piece arrive, plus a margin for requests still in the pipeline.
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(int w, int h, int img);
      wait_idle();
      csr_write(CSR_DEV_WIDTH, w);
      csr_write(CSR_DEV_HEIGHT, h);
      csr_write(CSR_IMAGE_HEIGHT, img);
      geo_w = w;
      geo_h = h;
      settings_used++;
   endtask

   initial begin
      rects_sent    = 0;
      settings_used = 1;
      calm_left     = 0;
      geo_w         = 512;
      geo_h         = 480;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset geometry: empty and inverted, every split shape, exact fit, oversize, underflow.
      send_rect(rect(10, 20, 10, 200));
      send_rect(rect(10, 20, 100, 20));
      send_rect(rect(100, 20, 10, 200));
      send_rect(rect(10, 200, 100, 20));
      send_rect(rect(10, 20, 100, 200));
      send_rect(rect(10, 470, 50, 490));
      send_rect(rect(500, 10, 530, 30));
      send_rect(rect(500, 470, 530, 490));
      send_rect(rect(1000, 900, 1100, 1000));
      send_rect(rect(0, 0, 512, 480));
      send_rect(rect(0, 0, 513, 10));
      send_rect(rect(0, 0, 10, 481));
      send_rect(rect(4094, 4094, 4095, 4095));
      send_rect(rect(0, 0, 4095, 4095));

      set_geometry(2048, 2048, 4095);
      send_rect(rect(2000, 2000, 2100, 2100));
      send_rect(rect(0, 0, 2048, 2048));
      send_rect(rect(2047, 0, 4095, 10));
      send_rect(rect(0, 0, 2049, 10));

      set_geometry(1, 1, 1);
      send_rect(rect(5, 5, 6, 6));
      send_rect(rect(5, 5, 7, 6));
      send_rect(rect(4094, 0, 4095, 1));

      // A zero device size makes any non-empty rectangle oversized.
      set_geometry(0, 480, 960);
      send_rect(rect(1, 1, 2, 2));
      send_rect(rect(3, 3, 3, 9));
      set_geometry(512, 0, 960);
      send_rect(rect(1, 1, 2, 2));

      repeat (6) begin
         set_geometry(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                  : $urandom_range(17, 2048),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                  : $urandom_range(17, 2048),
                      $urandom_range(1, 4095));
         repeat (45) send_rect(random_rect());
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d rectangles under %0d device geometries; %0d pieces came back.",
               rects_sent, settings_used, pieces_seen);
      $display("Mismatches: %0d, pieces still expected: %0d.", fail_count, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
